// ----- rtl/bitmap_block_allocator_with_handles_top_defines.svh -----
// assertion macros used by the port checker file
`ifndef BITMAP_BLOCK_ALLOCATOR_WITH_HANDLES_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_WITH_HANDLES_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bba_pkg.sv -----
// package: sizes, codes, types and helpers of the block allocator
package bba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int HCNT_W     = BLK_W + 1;

  // map words
  localparam int WORD_W    = (NUM_BLOCKS < 64) ? NUM_BLOCKS : 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = NUM_BLOCKS / WORD_W;
  localparam int ROW_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam int NUM_OWNERS = 4;
  localparam int OWNER_W    = 2;
  localparam int LIVE_W     = NUM_OWNERS * WORD_W;
  localparam int ENTRY_W    = BLK_W + OWNER_W;

  // stream fields
  localparam int CMD_W      = 2;
  localparam int ID_W       = 10;
  localparam int SIZE_W     = 25;
  localparam int STATUS_W   = 3;
  localparam int HANDLE_W   = 10;
  localparam int BLKIDX_W   = 10;
  localparam int OFS_W      = 48;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USED_W  = OWNER_W + ID_W + SIZE_W;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USED_W = HANDLE_W + BLKIDX_W + OFS_W;
  localparam int CMP_W      = (ID_W > HCNT_W) ? ID_W : HCNT_W;

  // configuration
  localparam int BASE_W     = 40;
  localparam int BSIZE_W    = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam logic [BSIZE_W-1:0] BLOB_SIZE_RST = BSIZE_W'(4096);

  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOB_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USER_OWNER = 2'd2;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic [BASE_W-1:0]  data_base;
    logic [BSIZE_W-1:0] blob_size;
    logic [OWNER_W-1:0] user_owner;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [BLK_W-1:0] blk;
  } ofs_req_t;

  // index of the lowest set bit, zero for an empty word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BLK_W-1:0] join_idx(input logic [ROW_W-1:0] row,
                                                input logic [BIT_W-1:0] pos);
    return (BLK_W'(row) << BIT_W) | BLK_W'(pos);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [BLK_W-1:0] idx);
    return ROW_W'(idx >> BIT_W);
  endfunction

endpackage

// ----- rtl/bba_ram.sv -----
// generic single-write, single-read ram with registered read data
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/bba_ofs.sv -----
// two-stage byte offset unit: data_base + block * blob_size
module bba_ofs import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  ofs_req_t         req_i,
  output logic             done_o,
  output logic [OFS_W-1:0] ofs_o
);

  localparam int PROD_W = BLK_W + BSIZE_W;

  logic              v1_q, v2_q;
  logic [PROD_W-1:0] prod_q;
  logic [OFS_W-1:0]  sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(req_i.blk) * PROD_W'(cfg_i.blob_size);
    sum_q  <= OFS_W'(cfg_i.data_base) + OFS_W'(prod_q);
  end

  assign done_o = v2_q;
  assign ofs_o  = sum_q;

endmodule

// ----- rtl/bba_ctrl.sv -----
// command sequencer around the free map, live map and handle table memories
module bba_ctrl import bba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    in_cmd_i,
  input  logic [OWNER_W-1:0]  in_owner_i,
  input  logic [ID_W-1:0]     in_id_i,
  input  logic [SIZE_W-1:0]   in_size_i,
  output ofs_req_t            ofs_req_o,
  input  logic                ofs_done_i,
  input  logic [OFS_W-1:0]    ofs_val_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [BLKIDX_W-1:0] out_blk_o,
  output logic [OFS_W-1:0]    out_ofs_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FSCAN = 4'd1;
  localparam logic [3:0] S_LSCAN = 4'd2;
  localparam logic [3:0] S_LCHK  = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_ALIVE = 4'd5;
  localparam logic [3:0] S_ENTRY = 4'd6;
  localparam logic [3:0] S_OFS   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam int LIDX_W = OWNER_W + BIT_W;

  logic [3:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [OWNER_W-1:0]    own_q, own_d;
  logic [BLK_W-1:0]      id_q, id_d;
  logic [BLK_W-1:0]      blk_q, blk_d;
  logic [HANDLE_W-1:0]   hdl_q, hdl_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [OFS_W-1:0]      res_ofs_q, res_ofs_d;
  logic [ROW_W:0]        scan_q, scan_d;
  logic                  pend_q, pend_d;
  logic [ROW_W-1:0]      chk_q, chk_d;
  logic [HCNT_W-1:0]     next_q, next_d;
  logic [NUM_WORDS-1:0]  fvalid_q, fvalid_d;
  logic [NUM_WORDS-1:0]  lvalid_q, lvalid_d;
  logic [ROW_W-1:0]      f_rrow_q, l_rrow_q;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [HANDLE_W-1:0]   out_handle_q, out_handle_d;
  logic [BLKIDX_W-1:0]   out_blk_q, out_blk_d;
  logic [OFS_W-1:0]      out_ofs_q, out_ofs_d;

  // memory ports
  logic                  f_we, l_we, e_we;
  logic [ROW_W-1:0]      f_waddr, f_raddr, l_waddr, l_raddr;
  logic [WORD_W-1:0]     f_wdata, f_rdata, f_word;
  logic [LIVE_W-1:0]     l_wdata, l_rdata, l_word;
  logic [BLK_W-1:0]      e_waddr, e_raddr;
  logic [ENTRY_W-1:0]    e_wdata, e_rdata;

  // helpers
  logic [ROW_W-1:0]      scan_row;
  logic                  scan_go, scan_last;
  logic [WORD_W-1:0]     user_lane;
  logic [BIT_W-1:0]      f_pos, l_pos;
  logic [LIVE_W-1:0]     clr_mask;
  logic                  live_any;
  logic [BLK_W-1:0]      e_blk;
  logic [ROW_W-1:0]      next_row;

  bba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  bba_ram #(.WIDTH(LIVE_W), .DEPTH(NUM_WORDS)) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  bba_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BLOCKS)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // rows never written read as their reset value
  assign f_word    = fvalid_q[f_rrow_q] ? f_rdata : '1;
  assign l_word    = lvalid_q[l_rrow_q] ? l_rdata : '0;
  assign user_lane = l_word[{cfg_i.user_owner, BIT_W'(0)} +: WORD_W];
  assign f_pos     = lowest_set(f_word);
  assign l_pos     = lowest_set(user_lane);
  assign e_blk     = e_rdata[ENTRY_W-1:OWNER_W];
  assign scan_row  = scan_q[ROW_W-1:0];
  assign scan_go   = (scan_q < (ROW_W + 1)'(NUM_WORDS));
  assign scan_last = (chk_q == ROW_W'(NUM_WORDS - 1));
  assign next_row  = row_of(next_q[BLK_W-1:0]);

  // one bit per owner lane at the checked handle
  always_comb begin
    clr_mask = '0;
    for (int o = 0; o < NUM_OWNERS; o++) begin
      clr_mask[{OWNER_W'(o), id_q[BIT_W-1:0]}] = 1'b1;
    end
    live_any = |(l_word & clr_mask);
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    own_d        = own_q;
    id_d         = id_q;
    blk_d        = blk_q;
    hdl_d        = hdl_q;
    status_d     = status_q;
    res_ofs_d    = res_ofs_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    chk_d        = chk_q;
    next_d       = next_q;
    fvalid_d     = fvalid_q;
    lvalid_d     = lvalid_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_blk_d    = out_blk_q;
    out_ofs_d    = out_ofs_q;

    f_we     = 1'b0;
    f_waddr  = chk_q;
    f_wdata  = f_word;
    f_raddr  = scan_row;
    l_we     = 1'b0;
    l_waddr  = l_rrow_q;
    l_wdata  = l_word;
    l_raddr  = scan_row;
    e_we     = 1'b0;
    e_waddr  = next_q[BLK_W-1:0];
    e_wdata  = {blk_q, own_q};
    e_raddr  = id_q;
    ofs_req_o = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_cmd_i;
          hdl_d     = '0;
          blk_d     = '0;
          res_ofs_d = '0;
          scan_d    = '0;
          pend_d    = 1'b0;
          case (in_cmd_i)
            CMD_LOCATE, CMD_FREE: begin
              hdl_d = HANDLE_W'(in_id_i);
              id_d  = BLK_W'(in_id_i);
              if (CMP_W'(in_id_i) >= CMP_W'(next_q)) begin
                status_d = ST_RANGE;
                state_d  = S_OUT;
              end else begin
                e_raddr = BLK_W'(in_id_i);
                l_raddr = row_of(BLK_W'(in_id_i));
                state_d = S_LCHK;
              end
            end
            CMD_FIND: begin
              own_d = cfg_i.user_owner;
              if (cfg_i.blob_size > in_size_i) begin
                state_d = S_LSCAN;
              end else if (next_q >= HCNT_W'(NUM_BLOCKS)) begin
                status_d = ST_EXHAUSTED;
                state_d  = S_OUT;
              end else begin
                state_d = S_FSCAN;
              end
            end
            default: begin
              own_d = in_owner_i;
              if (next_q >= HCNT_W'(NUM_BLOCKS)) begin
                status_d = ST_EXHAUSTED;
                state_d  = S_OUT;
              end else begin
                state_d = S_FSCAN;
              end
            end
          endcase
        end
      end

      // word-serial search for the lowest free block
      S_FSCAN: begin
        f_raddr = scan_row;
        pend_d  = scan_go;
        chk_d   = scan_row;
        if (scan_go) begin
          scan_d = scan_q + 1'b1;
        end
        if (pend_q) begin
          if (f_word != '0) begin
            blk_d           = join_idx(chk_q, f_pos);
            hdl_d           = HANDLE_W'(next_q[BLK_W-1:0]);
            f_we            = 1'b1;
            f_waddr         = chk_q;
            f_wdata         = f_word & ~(WORD_W'(1) << f_pos);
            fvalid_d[chk_q] = 1'b1;
            e_we            = 1'b1;
            e_waddr         = next_q[BLK_W-1:0];
            e_wdata         = {join_idx(chk_q, f_pos), own_q};
            l_raddr         = next_row;
            state_d         = S_ALIVE;
          end else if (scan_last) begin
            status_d = ST_NO_BLOCK;
            state_d  = S_OUT;
          end
        end
      end

      // mark the new handle live in its owner lane
      S_ALIVE: begin
        l_we               = 1'b1;
        l_waddr            = l_rrow_q;
        l_wdata            = l_word | (LIVE_W'(1) << LIDX_W'({own_q,
                                                         next_q[BIT_W-1:0]}));
        lvalid_d[l_rrow_q] = 1'b1;
        next_d             = next_q + 1'b1;
        status_d           = ST_OK;
        ofs_req_o.start    = 1'b1;
        ofs_req_o.blk      = blk_q;
        state_d            = S_OFS;
      end

      // word-serial search for the lowest live user handle
      S_LSCAN: begin
        l_raddr = scan_row;
        pend_d  = scan_go;
        chk_d   = scan_row;
        if (scan_go) begin
          scan_d = scan_q + 1'b1;
        end
        if (pend_q) begin
          if (user_lane != '0) begin
            hdl_d   = HANDLE_W'(join_idx(chk_q, l_pos));
            e_raddr = join_idx(chk_q, l_pos);
            state_d = S_ENTRY;
          end else if (scan_last) begin
            scan_d = '0;
            pend_d = 1'b0;
            if (next_q >= HCNT_W'(NUM_BLOCKS)) begin
              status_d = ST_EXHAUSTED;
              state_d  = S_OUT;
            end else begin
              state_d = S_FSCAN;
            end
          end
        end
      end

      S_ENTRY: begin
        blk_d           = e_blk;
        status_d        = ST_OK;
        ofs_req_o.start = 1'b1;
        ofs_req_o.blk   = e_blk;
        state_d         = S_OFS;
      end

      // entry and live row are back for locate or free
      S_LCHK: begin
        if (!live_any) begin
          status_d = ST_NOT_LIVE;
          state_d  = S_OUT;
        end else begin
          blk_d = e_blk;
          if (cmd_q == CMD_FREE) begin
            l_we               = 1'b1;
            l_waddr            = l_rrow_q;
            l_wdata            = l_word & ~clr_mask;
            lvalid_d[l_rrow_q] = 1'b1;
            f_raddr            = row_of(e_blk);
            state_d            = S_FRD;
          end else begin
            status_d        = ST_OK;
            ofs_req_o.start = 1'b1;
            ofs_req_o.blk   = e_blk;
            state_d         = S_OFS;
          end
        end
      end

      // return the released block to the free map
      S_FRD: begin
        f_we               = 1'b1;
        f_waddr            = f_rrow_q;
        f_wdata            = f_word | (WORD_W'(1) << blk_q[BIT_W-1:0]);
        fvalid_d[f_rrow_q] = 1'b1;
        status_d           = ST_OK;
        ofs_req_o.start    = 1'b1;
        ofs_req_o.blk      = blk_q;
        state_d            = S_OFS;
      end

      S_OFS: begin
        if (ofs_done_i) begin
          res_ofs_d = ofs_val_i;
          state_d   = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_handle_d = hdl_q;
          out_blk_d    = BLKIDX_W'(blk_q);
          out_ofs_d    = res_ofs_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      chk_q       <= '0;
      next_q      <= '0;
      fvalid_q    <= '0;
      lvalid_q    <= '0;
      f_rrow_q    <= '0;
      l_rrow_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      chk_q       <= chk_d;
      next_q      <= next_d;
      fvalid_q    <= fvalid_d;
      lvalid_q    <= lvalid_d;
      f_rrow_q    <= f_raddr;
      l_rrow_q    <= l_raddr;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    own_q        <= own_d;
    id_q         <= id_d;
    blk_q        <= blk_d;
    hdl_q        <= hdl_d;
    status_q     <= status_d;
    res_ofs_q    <= res_ofs_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_blk_q    <= out_blk_d;
    out_ofs_q    <= out_ofs_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_handle_o = out_handle_q;
  assign out_blk_o    = out_blk_q;
  assign out_ofs_o    = out_ofs_q;

endmodule

// ----- rtl/bitmap_block_allocator_with_handles_top.sv -----
// top level: bitmap first-fit block allocator with a handle table
// one command at a time; allocate, find-available, locate and free results pass through the
// offset unit, error results do not; allocate scans the free map word by word for the lowest
// free block, and find-available may scan the user's live lane first and then allocate
// the next command is taken the cycle after the result loads, even while that beat waits
// reset: registers to reset values, all blocks free, no live handle, next handle 0
module bitmap_block_allocator_with_handles_top import bba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // command beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // owner, blob_id, req_size, zero pad
  input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd
  // result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // handle, block_index, byte_offset, zero pad
  output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

  cfg_t                cfg_q, cfg_d;
  ofs_req_t            ofs_req;
  logic                ofs_done;
  logic [OFS_W-1:0]    ofs_val;
  logic [HANDLE_W-1:0] res_handle;
  logic [BLKIDX_W-1:0] res_blk;
  logic [OFS_W-1:0]    res_ofs;

  // register writes, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DATA_BASE:  cfg_d.data_base  = cfg_data_i[BASE_W-1:0];
        REG_BLOB_SIZE:  cfg_d.blob_size  = cfg_data_i[BSIZE_W-1:0];
        REG_USER_OWNER: cfg_d.user_owner = cfg_data_i[OWNER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_base  <= '0;
      cfg_q.blob_size  <= BLOB_SIZE_RST;
      cfg_q.user_owner <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencer with the three memories
  bba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_owner_i   (s_axis_tdata[OWNER_W-1:0]),
    .in_id_i      (s_axis_tdata[OWNER_W +: ID_W]),
    .in_size_i    (s_axis_tdata[OWNER_W + ID_W +: SIZE_W]),
    .ofs_req_o    (ofs_req),
    .ofs_done_i   (ofs_done),
    .ofs_val_i    (ofs_val),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_handle_o (res_handle),
    .out_blk_o    (res_blk),
    .out_ofs_o    (res_ofs)
  );

  // multiply-add for the byte offset
  bba_ofs u_ofs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (ofs_req),
    .done_o (ofs_done),
    .ofs_o  (ofs_val)
  );

  assign m_axis_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), res_ofs, res_blk, res_handle};

endmodule

// ----- rtl/bba_chk.sv -----
// port checker for the block allocator, bound to the top level
`include "bitmap_block_allocator_with_handles_top_defines.svh"

module bba_chk import bba_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // a stalled result beat holds
  `BBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // one command at a time: ready drops right after a command beat
  `BBA_ASSERT_NEXT(a_one_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command taken while busy")

  // status codes stay within the defined set
  `BBA_ASSERT_NOW(a_status, m_axis_tvalid, m_axis_tuser <= ST_EXHAUSTED, "undefined status")

  // error results carry no block and no offset
  `BBA_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[OUT_DATA_W-1:HANDLE_W] == '0, "error result with block data")

endmodule

bind bitmap_block_allocator_with_handles_top bba_chk u_bba_chk (.*);
